/* src/esc_pkg.sv */
// ----------------------------------------------------------------------------
// esc_pkg
// Shared types, codes and constants of the SCAN elevator controller.
// ----------------------------------------------------------------------------
package esc_pkg;

  localparam int unsigned FloorsDef = 8;
  localparam int unsigned FloorW    = 4;

  localparam logic [15:0] DoorOpenTimeRst = 16'd3000;
  localparam logic [15:0] MoveTimeoutRst  = 16'd8000;

  // register select is paddr[2]
  localparam logic RegDoorOpenTime = 1'b0;
  localparam logic RegMoveTimeout  = 1'b1;

  typedef enum logic [2:0] {
    MODE_IDLE         = 3'd0,
    MODE_MOVING       = 3'd1,
    MODE_DOOR_OPEN    = 3'd2,
    MODE_DOOR_CLOSING = 3'd3,
    MODE_FAULT        = 3'd4
  } mode_e;

  typedef enum logic [1:0] {
    HEAD_IDLE = 2'd0,
    HEAD_UP   = 2'd1,
    HEAD_DOWN = 2'd2
  } dir_e;

  typedef enum logic [2:0] {
    CMD_STOP      = 3'd0,
    CMD_UP        = 3'd1,
    CMD_DOWN      = 3'd2,
    CMD_SLOW_UP   = 3'd3,
    CMD_SLOW_DOWN = 3'd4
  } motor_cmd_e;

  typedef enum logic [1:0] {
    ST_WAIT,
    ST_CALL,
    ST_SCAN,
    ST_EXEC
  } ctrl_state_e;

  typedef struct packed {
    logic [31:0]       now_ms;
    logic              call_valid;
    logic [FloorW-1:0] call_floor;
    logic [FloorW-1:0] sensed_floor;
    logic              motor_halted;
  } in_t;

  typedef struct packed {
    logic              motor_cmd_valid;
    logic [2:0]        motor_cmd;
    logic [2:0]        mode;
    logic [FloorW-1:0] current_floor;
    logic [1:0]        direction;
  } out_t;

  // controller -> datapath
  typedef struct packed {
    logic capture;
    logic record;
    logic scan;
    logic commit;
  } dp_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic out_free;
  } dp_sts_t;

endpackage

/* src/esc_ctrl.sv */
// ----------------------------------------------------------------------------
// esc_ctrl
// Sequencer: capture word, record call, scan flags, commit update.
// ----------------------------------------------------------------------------
module esc_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  esc_pkg::dp_sts_t sts_i,
  output esc_pkg::dp_cmd_t cmd_o
);

  esc_pkg::ctrl_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= esc_pkg::ST_WAIT;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    in_ready_o = 1'b0;
    cmd_o      = '0;
    unique case (state_q)
      esc_pkg::ST_WAIT: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = esc_pkg::ST_CALL;
        end
      end
      esc_pkg::ST_CALL: begin
        cmd_o.record = 1'b1;
        state_d      = esc_pkg::ST_SCAN;
      end
      esc_pkg::ST_SCAN: begin
        cmd_o.scan = 1'b1;
        state_d    = esc_pkg::ST_EXEC;
      end
      esc_pkg::ST_EXEC: begin
        // hold until the output register can take the result
        if (sts_i.out_free) begin
          cmd_o.commit = 1'b1;
          state_d      = esc_pkg::ST_WAIT;
        end
      end
      default: state_d = esc_pkg::ST_WAIT;
    endcase
  end

  a_one_word_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o)
    else $error("input accepted while an update is in progress");

  a_commit_needs_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.scan |=> (state_q == esc_pkg::ST_EXEC))
    else $error("scan not followed by commit stage");

  a_commit_when_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.commit |-> sts_i.out_free)
    else $error("commit while the output register is full");

endmodule

/* src/esc_datapath.sv */
// ----------------------------------------------------------------------------
// esc_datapath
// Car state, request flags, SCAN target search, timers and output register.
// ----------------------------------------------------------------------------
module esc_datapath #(
  parameter int unsigned FLOORS = esc_pkg::FloorsDef
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  esc_pkg::dp_cmd_t cmd_i,
  output esc_pkg::dp_sts_t sts_o,
  input  esc_pkg::in_t     in_data_i,
  input  logic [15:0]      door_open_time_i,
  input  logic [15:0]      move_timeout_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output esc_pkg::out_t    out_data_o
);

  localparam int unsigned FW = esc_pkg::FloorW;
  localparam logic [FW-1:0] FloorsV = FW'(FLOORS);

  // car state
  esc_pkg::mode_e  mode_q, mode_d;
  esc_pkg::dir_e   dir_q, dir_d;
  logic [FW-1:0]   floor_q, floor_d;
  logic [FW-1:0]   target_q, target_d;
  logic [FLOORS:1] flags_q, flags_d;
  logic [31:0]     door_start_q, door_start_d;
  logic [31:0]     move_start_q, move_start_d;
  logic            out_valid_q;

  // captured word and scan results
  esc_pkg::in_t    in_q;
  logic [FW-1:0]   up_q, down_q, up_c, down_c;
  logic            any_q, here_q, hit_q, sensed_ok_q;
  logic            here_c, hit_c;
  logic [31:0]     door_el_q, move_el_q;
  esc_pkg::out_t   out_q, out_d;

  // update datapath
  logic            clr_en;
  logic [FW-1:0]   clr_floor;
  logic [FW-1:0]   tgt;
  logic            adj;
  esc_pkg::dir_e   dir_n;

  assign sts_o.out_free = !out_valid_q || out_ready_i;
  assign out_valid_o    = out_valid_q;
  assign out_data_o     = out_q;

  // priority searches over the request flags
  always_comb begin
    up_c   = '0;
    down_c = '0;
    here_c = 1'b0;
    hit_c  = 1'b0;
    for (int f = FLOORS; f >= 1; f--) begin
      if (flags_q[f] && (FW'(f) > floor_q)) up_c = FW'(f);
    end
    for (int f = 1; f <= FLOORS; f++) begin
      if (flags_q[f] && (FW'(f) < floor_q)) down_c = FW'(f);
      if (flags_q[f] && (FW'(f) == floor_q)) here_c = 1'b1;
      if (flags_q[f] && (FW'(f) == in_q.sensed_floor)) hit_c = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      in_q <= in_data_i;
    end
    if (cmd_i.scan) begin
      up_q        <= up_c;
      down_q      <= down_c;
      any_q       <= |flags_q;
      here_q      <= here_c;
      hit_q       <= hit_c;
      sensed_ok_q <= (in_q.sensed_floor != '0) && (in_q.sensed_floor <= FloorsV) &&
                     (in_q.sensed_floor != floor_q);
      door_el_q   <= in_q.now_ms - door_start_q;
      move_el_q   <= in_q.now_ms - move_start_q;
    end
    if (cmd_i.commit) begin
      out_q <= out_d;
    end
  end

  always_comb begin
    mode_d       = mode_q;
    dir_d        = dir_q;
    floor_d      = floor_q;
    target_d     = target_q;
    door_start_d = door_start_q;
    move_start_d = move_start_q;
    clr_en       = 1'b0;
    clr_floor    = floor_q;
    tgt          = '0;
    adj          = 1'b0;
    dir_n        = dir_q;
    out_d        = '0;

    unique case (mode_q)
      esc_pkg::MODE_IDLE: begin
        if (!any_q) begin
          dir_d = esc_pkg::HEAD_IDLE;
        end else if (here_q) begin
          clr_en       = 1'b1;
          mode_d       = esc_pkg::MODE_DOOR_OPEN;
          door_start_d = in_q.now_ms;
        end else begin
          // SCAN: keep direction, reverse when nothing lies ahead
          if (dir_q == esc_pkg::HEAD_IDLE) begin
            if (up_q != '0) dir_n = esc_pkg::HEAD_UP;
            else if (down_q != '0) dir_n = esc_pkg::HEAD_DOWN;
          end
          if (dir_n == esc_pkg::HEAD_UP) begin
            if (up_q != '0) begin
              tgt = up_q;
            end else if (down_q != '0) begin
              dir_n = esc_pkg::HEAD_DOWN;
              tgt   = down_q;
            end
          end else begin
            if (down_q != '0) begin
              tgt = down_q;
            end else if (up_q != '0) begin
              dir_n = esc_pkg::HEAD_UP;
              tgt   = up_q;
            end
          end
          dir_d = dir_n;
          if (tgt != '0) begin
            adj = ({1'b0, tgt} == {1'b0, floor_q} + 1'b1) ||
                  ({1'b0, tgt} + 1'b1 == {1'b0, floor_q});
            target_d              = tgt;
            out_d.motor_cmd_valid = 1'b1;
            if (dir_n == esc_pkg::HEAD_UP) begin
              out_d.motor_cmd = adj ? esc_pkg::CMD_SLOW_UP : esc_pkg::CMD_UP;
            end else begin
              out_d.motor_cmd = adj ? esc_pkg::CMD_SLOW_DOWN : esc_pkg::CMD_DOWN;
            end
            move_start_d = in_q.now_ms;
            mode_d       = esc_pkg::MODE_MOVING;
          end
        end
      end
      esc_pkg::MODE_MOVING: begin
        if (move_el_q > {16'b0, move_timeout_i}) begin
          out_d.motor_cmd_valid = 1'b1;
          out_d.motor_cmd       = esc_pkg::CMD_STOP;
          mode_d                = esc_pkg::MODE_FAULT;
        end else if (sensed_ok_q) begin
          floor_d      = in_q.sensed_floor;
          move_start_d = in_q.now_ms;
          if ((in_q.sensed_floor == target_q) || hit_q) begin
            out_d.motor_cmd_valid = 1'b1;
            out_d.motor_cmd       = esc_pkg::CMD_STOP;
            clr_en                = 1'b1;
            clr_floor             = in_q.sensed_floor;
            target_d              = '0;
            mode_d                = esc_pkg::MODE_DOOR_OPEN;
            door_start_d          = in_q.now_ms;
          end else if ((dir_q == esc_pkg::HEAD_UP) &&
                       ({1'b0, in_q.sensed_floor} + 1'b1 == {1'b0, target_q})) begin
            out_d.motor_cmd_valid = 1'b1;
            out_d.motor_cmd       = esc_pkg::CMD_SLOW_UP;
          end else if ((dir_q == esc_pkg::HEAD_DOWN) &&
                       ({1'b0, in_q.sensed_floor} == {1'b0, target_q} + 1'b1)) begin
            out_d.motor_cmd_valid = 1'b1;
            out_d.motor_cmd       = esc_pkg::CMD_SLOW_DOWN;
          end
        end
      end
      esc_pkg::MODE_DOOR_OPEN: begin
        out_d.motor_cmd_valid = 1'b1;
        out_d.motor_cmd       = esc_pkg::CMD_STOP;
        if (door_el_q >= {16'b0, door_open_time_i}) mode_d = esc_pkg::MODE_DOOR_CLOSING;
      end
      esc_pkg::MODE_DOOR_CLOSING: begin
        if (in_q.motor_halted) mode_d = esc_pkg::MODE_IDLE;
      end
      esc_pkg::MODE_FAULT: begin
        out_d.motor_cmd_valid = 1'b1;
        out_d.motor_cmd       = esc_pkg::CMD_STOP;
      end
      default: mode_d = esc_pkg::MODE_IDLE;
    endcase

    out_d.mode          = mode_d;
    out_d.current_floor = floor_d;
    out_d.direction     = dir_d;
  end

  // request flags: set by a call, cleared when served
  always_comb begin
    flags_d = flags_q;
    for (int f = 1; f <= FLOORS; f++) begin
      if (cmd_i.record && in_q.call_valid && (in_q.call_floor == FW'(f))) flags_d[f] = 1'b1;
      if (cmd_i.commit && clr_en && (clr_floor == FW'(f))) flags_d[f] = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q       <= esc_pkg::MODE_IDLE;
      dir_q        <= esc_pkg::HEAD_IDLE;
      floor_q      <= FW'(1);
      target_q     <= '0;
      flags_q      <= '0;
      door_start_q <= '0;
      move_start_q <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      flags_q <= flags_d;
      if (cmd_i.commit) begin
        mode_q       <= mode_d;
        dir_q        <= dir_d;
        floor_q      <= floor_d;
        target_q     <= target_d;
        door_start_q <= door_start_d;
        move_start_q <= move_start_d;
        out_valid_q  <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  a_fault_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mode_q == esc_pkg::MODE_FAULT) |=> (mode_q == esc_pkg::MODE_FAULT))
    else $error("left fault without reset");

  a_floor_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (floor_q >= FW'(1)) && (floor_q <= FloorsV))
    else $error("car floor out of range");

  a_no_cmd_is_stop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_q.motor_cmd_valid) |-> (out_q.motor_cmd == esc_pkg::CMD_STOP))
    else $error("motor command set without valid");

endmodule

/* src/elevator_scan_controller_core.sv */
// ----------------------------------------------------------------------------
// elevator_scan_controller_core
// SCAN elevator controller: hall calls, mode machine, motor commands.
// ----------------------------------------------------------------------------
// Each input word is one update (time, optional hall call, floor sensor,
// motor halted) and yields exactly one output word (motor command, mode,
// floor, direction). An update runs through capture at the accepting edge,
// call recording, a priority search of the request flags together with the
// elapsed-time subtractions, and the state commit, which writes the result
// register once it is free. The next word can be accepted in the cycle after
// the commit. The sequencer works on one update at a time; a result waiting
// in the output register delays the commit of the next update only.
// door_open_time (0x0) and move_timeout (0x4) are written over the APB port;
// write them only while idle, which the block itself does not enforce.
module elevator_scan_controller_core #(
  parameter int unsigned FLOORS = esc_pkg::FloorsDef
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  esc_pkg::in_t  in_data_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output esc_pkg::out_t out_data_o,
  input  logic          psel,
  input  logic          penable,
  input  logic          pwrite,
  input  logic [2:0]    paddr,
  input  logic [31:0]   pwdata,
  output logic [31:0]   prdata,
  output logic          pready
);

  esc_pkg::dp_cmd_t dp_cmd;
  esc_pkg::dp_sts_t dp_sts;
  logic [15:0]      door_open_time_q;
  logic [15:0]      move_timeout_q;
  logic             reg_wr;

  assign pready = 1'b1;
  assign reg_wr = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      door_open_time_q <= esc_pkg::DoorOpenTimeRst;
      move_timeout_q   <= esc_pkg::MoveTimeoutRst;
    end else if (reg_wr) begin
      unique case (paddr[2])
        esc_pkg::RegDoorOpenTime: door_open_time_q <= pwdata[15:0];
        esc_pkg::RegMoveTimeout:  move_timeout_q   <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      esc_pkg::RegDoorOpenTime: prdata = {16'b0, door_open_time_q};
      esc_pkg::RegMoveTimeout:  prdata = {16'b0, move_timeout_q};
      default:                  prdata = '0;
    endcase
  end

  esc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sts_i      (dp_sts),
    .cmd_o      (dp_cmd)
  );

  esc_datapath #(
    .FLOORS (FLOORS)
  ) u_datapath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (dp_cmd),
    .sts_o            (dp_sts),
    .in_data_i        (in_data_i),
    .door_open_time_i (door_open_time_q),
    .move_timeout_i   (move_timeout_q),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .out_data_o       (out_data_o)
  );

endmodule

/* tb/esc_car_checker.sv */
// ----------------------------------------------------------------------------
// esc_car_checker
// Predicts the car status word for every accepted update and checks the DUT.
// ----------------------------------------------------------------------------
// Watches the update and status channels and the register port. Each accepted
// update advances a private copy of the controller state (modes, hall calls,
// SCAN direction, timers) and queues the predicted status word. Each accepted
// status word is checked field by field against the oldest prediction.
module esc_car_checker (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  input  logic          in_ready_i,
  input  esc_pkg::in_t  in_data_i,
  input  logic          out_valid_i,
  input  logic          out_ready_i,
  input  esc_pkg::out_t out_data_i,
  input  logic          psel_i,
  input  logic          penable_i,
  input  logic          pwrite_i,
  input  logic          pready_i,
  input  logic [2:0]    paddr_i,
  input  logic [31:0]   pwdata_i,
  output int unsigned   mismatch_cnt_o,
  output int unsigned   pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned ReportMax = 10;
  localparam int unsigned FW        = esc_pkg::FloorW;
  localparam int unsigned NFloors   = esc_pkg::FloorsDef;

  logic [15:0]      door_time;
  logic [15:0]      move_limit;
  esc_pkg::mode_e   car_mode;
  logic [FW-1:0]    car_floor;
  logic [FW-1:0]    car_target;
  esc_pkg::dir_e    car_dir;
  logic [NFloors:1] hall_calls;
  logic [31:0]      door_t0;
  logic [31:0]      move_t0;
  esc_pkg::out_t    car_status_q[$];

  function automatic logic [FW-1:0] call_above();
    for (int f = car_floor + 1; f <= NFloors; f++) begin
      if (hall_calls[f]) return FW'(f);
    end
    return '0;
  endfunction

  function automatic logic [FW-1:0] call_below();
    for (int f = car_floor - 1; f >= 1; f--) begin
      if (hall_calls[f]) return FW'(f);
    end
    return '0;
  endfunction

  // SCAN: keep heading, reverse only when nothing is ahead
  function automatic logic [FW-1:0] scan_pick();
    logic [FW-1:0] up;
    logic [FW-1:0] dn;
    up = call_above();
    dn = call_below();
    if (car_dir == esc_pkg::HEAD_IDLE) begin
      if (up != 0) car_dir = esc_pkg::HEAD_UP;
      else if (dn != 0) car_dir = esc_pkg::HEAD_DOWN;
      else return '0;
    end
    if (car_dir == esc_pkg::HEAD_UP) begin
      if (up != 0) return up;
      if (dn != 0) begin
        car_dir = esc_pkg::HEAD_DOWN;
        return dn;
      end
    end else begin
      if (dn != 0) return dn;
      if (up != 0) begin
        car_dir = esc_pkg::HEAD_UP;
        return up;
      end
    end
    return '0;
  endfunction

  function automatic esc_pkg::out_t advance_car(esc_pkg::in_t u);
    esc_pkg::out_t      r;
    logic               issued;
    esc_pkg::motor_cmd_e cmd;
    logic [FW-1:0]      t;
    logic [31:0]        elapsed;
    logic               adj;
    issued = 1'b0;
    cmd    = esc_pkg::CMD_STOP;
    if (u.call_valid && u.call_floor >= 1 && u.call_floor <= NFloors)
      hall_calls[u.call_floor] = 1'b1;
    case (car_mode)
      esc_pkg::MODE_IDLE: begin
        if (hall_calls == '0) begin
          car_dir = esc_pkg::HEAD_IDLE;
        end else if (hall_calls[car_floor]) begin
          hall_calls[car_floor] = 1'b0;
          car_mode = esc_pkg::MODE_DOOR_OPEN;
          door_t0  = u.now_ms;
        end else begin
          t = scan_pick();
          if (t != 0) begin
            adj        = (t == car_floor + 1) || (t + 1 == car_floor);
            car_target = t;
            issued     = 1'b1;
            if (car_dir == esc_pkg::HEAD_UP) begin
              cmd = adj ? esc_pkg::CMD_SLOW_UP : esc_pkg::CMD_UP;
            end else begin
              cmd = adj ? esc_pkg::CMD_SLOW_DOWN : esc_pkg::CMD_DOWN;
            end
            move_t0  = u.now_ms;
            car_mode = esc_pkg::MODE_MOVING;
          end
        end
      end
      esc_pkg::MODE_MOVING: begin
        elapsed = u.now_ms - move_t0;
        if (elapsed > {16'd0, move_limit}) begin
          issued   = 1'b1;
          cmd      = esc_pkg::CMD_STOP;
          car_mode = esc_pkg::MODE_FAULT;
        end else if (u.sensed_floor != 0 && u.sensed_floor <= NFloors &&
                     u.sensed_floor != car_floor) begin
          car_floor = u.sensed_floor;
          move_t0   = u.now_ms;
          if (car_floor == car_target || hall_calls[car_floor]) begin
            issued                = 1'b1;
            cmd                   = esc_pkg::CMD_STOP;
            hall_calls[car_floor] = 1'b0;
            car_target            = '0;
            car_mode              = esc_pkg::MODE_DOOR_OPEN;
            door_t0               = u.now_ms;
          end else if (car_dir == esc_pkg::HEAD_UP && car_floor + 1 == car_target) begin
            issued = 1'b1;
            cmd    = esc_pkg::CMD_SLOW_UP;
          end else if (car_dir == esc_pkg::HEAD_DOWN && car_floor == car_target + 1) begin
            issued = 1'b1;
            cmd    = esc_pkg::CMD_SLOW_DOWN;
          end
        end
      end
      esc_pkg::MODE_DOOR_OPEN: begin
        issued  = 1'b1;
        cmd     = esc_pkg::CMD_STOP;
        elapsed = u.now_ms - door_t0;
        if (elapsed >= {16'd0, door_time}) car_mode = esc_pkg::MODE_DOOR_CLOSING;
      end
      esc_pkg::MODE_DOOR_CLOSING: begin
        if (u.motor_halted) car_mode = esc_pkg::MODE_IDLE;
      end
      esc_pkg::MODE_FAULT: begin
        issued = 1'b1;
        cmd    = esc_pkg::CMD_STOP;
      end
      default: begin
        car_mode = esc_pkg::MODE_IDLE;
      end
    endcase
    r.motor_cmd_valid = issued;
    r.motor_cmd       = issued ? cmd : esc_pkg::CMD_STOP;
    r.mode            = car_mode;
    r.current_floor   = car_floor;
    r.direction       = car_dir;
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    esc_pkg::out_t want;
    logic bad;
    if (!rst_ni) begin
      door_time  = esc_pkg::DoorOpenTimeRst;
      move_limit = esc_pkg::MoveTimeoutRst;
      car_mode   = esc_pkg::MODE_IDLE;
      car_floor  = FW'(1);
      car_target = '0;
      car_dir    = esc_pkg::HEAD_IDLE;
      hall_calls = '0;
      door_t0    = '0;
      move_t0    = '0;
      car_status_q.delete();
      mismatch_cnt_o = 0;
      pending_o      = 0;
    end else begin
      // older word leaves first; a new update cannot reach the output in the same edge
      if (out_valid_i && out_ready_i) begin
        if (car_status_q.size() == 0) begin
          mismatch_cnt_o++;
          if (mismatch_cnt_o <= ReportMax)
            $display("%t: status word with nothing predicted: %p", $realtime, out_data_i);
        end else begin
          want = car_status_q.pop_front();
          bad  = (out_data_i.motor_cmd_valid !== want.motor_cmd_valid) ||
                 (out_data_i.motor_cmd       !== want.motor_cmd)       ||
                 (out_data_i.mode            !== want.mode)            ||
                 (out_data_i.current_floor   !== want.current_floor)   ||
                 (out_data_i.direction       !== want.direction);
          if (bad) begin
            mismatch_cnt_o++;
            if (mismatch_cnt_o <= ReportMax)
              $display("%t: status differs: exp cmd_v=%0d cmd=%0d mode=%0d floor=%0d dir=%0d,",
                       $realtime, want.motor_cmd_valid, want.motor_cmd, want.mode,
                       want.current_floor, want.direction,
                       " got cmd_v=%0d cmd=%0d mode=%0d floor=%0d dir=%0d",
                       out_data_i.motor_cmd_valid, out_data_i.motor_cmd, out_data_i.mode,
                       out_data_i.current_floor, out_data_i.direction);
          end
        end
      end
      if (psel_i && penable_i && pwrite_i && pready_i && paddr_i[1:0] == 2'b00) begin
        case (paddr_i[2])
          esc_pkg::RegDoorOpenTime: door_time  = pwdata_i[15:0];
          esc_pkg::RegMoveTimeout:  move_limit = pwdata_i[15:0];
          default: ;
        endcase
      end
      if (in_valid_i && in_ready_i) car_status_q.push_back(advance_car(in_data_i));
      pending_o = car_status_q.size();
    end
  end

endmodule

/* tb/tb_elevator_scan_controller_core.sv */
// ----------------------------------------------------------------------------
// tb_elevator_scan_controller_core
// Stimulus and verdict for the SCAN elevator controller core.
// ----------------------------------------------------------------------------
// A short directed walk (door cycle, stops on passed calls, slow-down floors,
// ignored calls and sensor values, time wrap) is followed by random phases
// under several register settings, ending with a forced move timeout. Sensor
// readings are paced so that a moving car never times out until the last
// phase. Both channels idle at random; the checker does the comparing.
module tb_elevator_scan_controller_core;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [31:0] WrapBase  = 32'hFFFF_E000;
  localparam int unsigned PhaseLen  = 150;
  localparam int unsigned HoldOff   = 300;
  localparam int unsigned FW        = esc_pkg::FloorW;
  localparam int unsigned NFloors   = esc_pkg::FloorsDef;

  typedef enum logic [1:0] {
    RX_STREAM,
    RX_COIN,
    RX_SPARSE,
    RX_BURSTY
  } rx_pace_e;

  logic          clk = 1'b0;
  logic          rst_n;
  logic          upd_valid;
  logic          upd_ready;
  esc_pkg::in_t  upd_word;
  logic          stat_valid;
  logic          stat_ready;
  esc_pkg::out_t stat_word;
  logic          psel;
  logic          penable;
  logic          pwrite;
  logic [2:0]    paddr;
  logic [31:0]   pwdata;
  logic [31:0]   prdata;
  logic          pready;
  int unsigned   mismatches;
  int unsigned   in_flight;

  logic [31:0] clock_ms;
  logic [3:0]  last_sensed;
  int unsigned since_sensed;
  int unsigned step_max;
  int unsigned burst_left;
  int unsigned hold_reqs = 0;

  always #1 clk = ~clk;

  elevator_scan_controller_core i_dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (upd_valid),
    .in_ready_o  (upd_ready),
    .in_data_i   (upd_word),
    .out_valid_o (stat_valid),
    .out_ready_i (stat_ready),
    .out_data_o  (stat_word),
    .psel,
    .penable,
    .pwrite,
    .paddr,
    .pwdata,
    .prdata,
    .pready
  );

  esc_car_checker i_checker (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .in_valid_i     (upd_valid),
    .in_ready_i     (upd_ready),
    .in_data_i      (upd_word),
    .out_valid_i    (stat_valid),
    .out_ready_i    (stat_ready),
    .out_data_i     (stat_word),
    .psel_i         (psel),
    .penable_i      (penable),
    .pwrite_i       (pwrite),
    .pready_i       (pready),
    .paddr_i        (paddr),
    .pwdata_i       (pwdata),
    .mismatch_cnt_o (mismatches),
    .pending_o      (in_flight)
  );

  task automatic send_update(input esc_pkg::in_t w);
    int unsigned gap;
    gap = 0;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      if ($urandom_range(0, 3) != 0) gap = $urandom_range(1, 12);
    end
    @(negedge clk);
    if (gap != 0) begin
      upd_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    upd_valid <= 1'b1;
    upd_word  <= w;
    do @(posedge clk); while (!upd_ready);
    burst_left--;
  endtask

  task automatic send_fields(input logic [31:0] t, input logic cv, input logic [3:0] cf,
                             input logic [3:0] sf, input logic h);
    esc_pkg::in_t w;
    clock_ms = t;
    w = '{now_ms: t, call_valid: cv, call_floor: cf, sensed_floor: sf, motor_halted: h};
    send_update(w);
  endtask

  // settle words hold the time still and force a fresh floor reading, which
  // pins the move timer to the present before a timeout change
  task automatic make_update(input bit settle, output esc_pkg::in_t w);
    int unsigned kind;
    logic [3:0]  s;
    if (!settle) clock_ms += $urandom_range(0, step_max);
    w.now_ms     = clock_ms;
    w.call_valid = ($urandom_range(0, 99) < 35);
    w.call_floor = ($urandom_range(0, 4) == 0) ? FW'($urandom_range(0, 15))
                                               : FW'($urandom_range(1, NFloors));
    kind = (settle || since_sensed >= 2) ? 0 : $urandom_range(0, 99);
    if (kind < 45) begin
      // successive floor readings always differ, so a moving car keeps changing floor
      do s = FW'($urandom_range(1, NFloors)); while (s == last_sensed);
      last_sensed  = s;
      since_sensed = 0;
    end else begin
      since_sensed++;
      s = (kind < 80) ? '0 : FW'($urandom_range(NFloors + 1, 15));
    end
    w.sensed_floor = s;
    w.motor_halted = ($urandom_range(0, 9) < 6);
  endtask

  task automatic drain();
    @(negedge clk);
    upd_valid <= 1'b0;
    while (in_flight != 0) @(negedge clk);
  endtask

  task automatic apb_write(input logic [2:0] addr, input logic [31:0] data);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic run_phase(input logic [15:0] door_ms, input logic [15:0] limit_ms,
                           input int unsigned n_items, input bit squeeze);
    esc_pkg::in_t w;
    repeat (3) begin
      make_update(1'b1, w);
      send_update(w);
    end
    drain();
    apb_write({esc_pkg::RegDoorOpenTime, 2'b00}, {16'($urandom), door_ms});
    apb_write({esc_pkg::RegMoveTimeout, 2'b00}, {16'($urandom), limit_ms});
    // six words at most between floor changes stay inside the timeout
    step_max = (limit_ms < 20) ? 1 : limit_ms / 10;
    for (int i = 0; i < n_items; i++) begin
      if (squeeze && i == n_items / 3) hold_reqs++;
      make_update(1'b0, w);
      send_update(w);
    end
  endtask

  // receiver pacing, with a long hold-off on request
  initial begin
    int unsigned run_left;
    int unsigned hold_left;
    int unsigned holds_done;
    rx_pace_e    pace;
    stat_ready = 1'b0;
    run_left   = 0;
    holds_done = 0;
    pace       = RX_STREAM;
    forever begin
      @(negedge clk);
      if (hold_reqs != holds_done) begin
        holds_done++;
        stat_ready <= 1'b0;
        hold_left = HoldOff;
        while (hold_left != 0) begin
          @(negedge clk);
          hold_left--;
        end
      end else begin
        if (run_left == 0) begin
          run_left = $urandom_range(4, 40);
          pace     = rx_pace_e'($urandom_range(0, 3));
        end
        run_left--;
        case (pace)
          RX_STREAM: stat_ready <= 1'b1;
          RX_COIN:   stat_ready <= 1'($urandom_range(0, 1));
          RX_SPARSE: stat_ready <= ($urandom_range(0, 4) == 0);
          default:   stat_ready <= (run_left[1:0] != 2'b00);
        endcase
      end
    end
  end

  initial begin
    #1_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin
    rst_n        = 1'b0;
    upd_valid    = 1'b0;
    upd_word     = '0;
    psel         = 1'b0;
    penable      = 1'b0;
    pwrite       = 1'b0;
    paddr        = '0;
    pwdata       = '0;
    clock_ms     = WrapBase;
    last_sensed  = '0;
    since_sensed = 0;
    step_max     = 1;
    burst_left   = 0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // directed walk under reset timings; the ms counter wraps midway
    send_fields(WrapBase + 100,   1'b0, 4'd0,  4'd0,  1'b0);  // no calls at all
    send_fields(WrapBase + 110,   1'b1, 4'd0,  4'd0,  1'b1);  // floor zero call ignored
    send_fields(WrapBase + 120,   1'b1, 4'd15, 4'd15, 1'b0);  // call and sensor out of range
    send_fields(WrapBase + 130,   1'b1, 4'd1,  4'd0,  1'b0);  // call at current floor
    send_fields(WrapBase + 140,   1'b0, 4'd0,  4'd0,  1'b0);
    send_fields(WrapBase + 3140,  1'b0, 4'd0,  4'd0,  1'b0);  // door starts closing
    send_fields(WrapBase + 3150,  1'b0, 4'd0,  4'd0,  1'b0);  // motor not halted yet
    send_fields(WrapBase + 3160,  1'b0, 4'd0,  4'd0,  1'b1);
    send_fields(WrapBase + 3170,  1'b1, 4'd8,  4'd0,  1'b1);  // long run up
    send_fields(WrapBase + 3180,  1'b1, 4'd5,  4'd2,  1'b0);
    send_fields(WrapBase + 3190,  1'b0, 4'd0,  4'd3,  1'b0);
    send_fields(WrapBase + 3200,  1'b0, 4'd0,  4'd4,  1'b0);
    send_fields(WrapBase + 3210,  1'b0, 4'd0,  4'd5,  1'b0);  // stop at a passed call
    send_fields(WrapBase + 6300,  1'b0, 4'd0,  4'd0,  1'b1);
    send_fields(WrapBase + 6310,  1'b0, 4'd0,  4'd0,  1'b1);
    send_fields(WrapBase + 6320,  1'b0, 4'd0,  4'd0,  1'b0);
    send_fields(WrapBase + 6330,  1'b0, 4'd0,  4'd7,  1'b0);  // slow up one floor early
    send_fields(WrapBase + 6340,  1'b1, 4'd2,  4'd8,  1'b0);
    send_fields(WrapBase + 9400,  1'b0, 4'd0,  4'd0,  1'b1);  // door time across the wrap
    send_fields(WrapBase + 9410,  1'b0, 4'd0,  4'd0,  1'b1);
    send_fields(WrapBase + 9420,  1'b0, 4'd0,  4'd0,  1'b0);  // reverse to head down
    send_fields(WrapBase + 9430,  1'b0, 4'd0,  4'd3,  1'b0);
    send_fields(WrapBase + 9440,  1'b0, 4'd0,  4'd2,  1'b0);
    send_fields(WrapBase + 12500, 1'b0, 4'd0,  4'd0,  1'b1);
    send_fields(WrapBase + 12510, 1'b1, 4'd1,  4'd9,  1'b1);  // next: adjacent slow down

    run_phase(16'd200, 16'd8000, PhaseLen, 1'b1);
    run_phase(16'd0, 16'd65535, PhaseLen, 1'b0);
    run_phase(16'd65535, 16'd65535, PhaseLen, 1'b0);
    run_phase(16'($urandom_range(0, 5000)), 16'($urandom_range(2000, 65535)), PhaseLen, 1'b1);
    run_phase(16'd3, 16'd40, PhaseLen, 1'b0);
    run_phase(16'($urandom), 16'($urandom_range(20000, 65535)), PhaseLen, 1'b0);
    run_phase(16'($urandom_range(0, 2000)), 16'($urandom_range(100, 20000)), PhaseLen, 1'b0);
    // zero timeout: the first move that lets time pass ends in fault
    run_phase(16'($urandom_range(0, 300)), 16'd0, 30, 1'b0);

    drain();
    repeat (20) @(negedge clk);
    if (mismatches == 0 && in_flight == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
